>>> hdl/rgsm_pkg.sv
// Shared types and register codes for the ramped-gain speaker mixer.
// No dependencies; imported by the mixer top level.
package rgsm_pkg;

  // Number of speaker channels handled per frame.
  localparam int unsigned NumSpk = 6;

  // Configuration register indexes, one per 8-byte slot.
  typedef enum logic [2:0] {
    REG_SIX_SPEAKERS     = 3'd0,
    REG_SOURCE_STEREO    = 3'd1,
    REG_START_GAINS_LOW  = 3'd2,
    REG_START_GAINS_HIGH = 3'd3,
    REG_END_GAINS_LOW    = 3'd4,
    REG_END_GAINS_HIGH   = 3'd5
  } cfg_reg_e;

  // One source frame with the existing mix accumulators.
  typedef struct packed {
    logic               block_start;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic signed [31:0] mix_in_0;
    logic signed [31:0] mix_in_1;
    logic signed [31:0] mix_in_2;
    logic signed [31:0] mix_in_3;
    logic signed [31:0] mix_in_4;
    logic signed [31:0] mix_in_5;
  } in_item_t;

  // Updated accumulators for one frame.
  typedef struct packed {
    logic signed [31:0] mix_out_0;
    logic signed [31:0] mix_out_1;
    logic signed [31:0] mix_out_2;
    logic signed [31:0] mix_out_3;
    logic signed [31:0] mix_out_4;
    logic signed [31:0] mix_out_5;
  } out_item_t;

endpackage

>>> hdl/ramped_gain_speaker_mixer.sv
// Ramped-gain speaker mixer: gain ramp state, multiply-accumulate datapath
// and configuration registers. Depends on rgsm_pkg.
//
// The mixer takes one frame per clock cycle while the output is not stalled and
// returns one result per frame. A frame is taken into the input register, where
// the per-speaker gains for the frame are latched, and then passes through the six
// 16-by-(16+log2(BLOCK_LEN)) multipliers, rounding adder and 32-bit saturation
// into the output register. A frame with block_start set reloads every ramp
// from the start and end gain registers; gain changes take effect only at the
// next block start. BLOCK_LEN must be a power of two between 2 and 65536.
// Registers sit at byte addresses 8*i; the user must write them only while the
// block holds no frames, as the block itself does not enforce this.
module ramped_gain_speaker_mixer
  import rgsm_pkg::*;
#(
  parameter int unsigned BLOCK_LEN = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Frame input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned L  = $clog2(BLOCK_LEN);
  localparam int unsigned GW = 16 + L;   // scaled gain width
  localparam int unsigned PW = 16 + GW;  // product width

  localparam logic signed [GW:0] GMax = {2'b00, 15'h7fff, {L{1'b0}}};
  localparam logic signed [GW:0] GMin = {2'b11, 15'h0000, {L{1'b0}}};
  localparam logic signed [PW:0] Half = {{(PW - 14 - L){1'b0}}, 1'b1, {(14 + L){1'b0}}};

  // Configuration registers
  logic        six_speakers_q;
  logic        source_stereo_q;
  logic [47:0] start_lo_q, start_hi_q, end_lo_q, end_hi_q;

  // Ramp state
  logic signed [GW-1:0] run_q  [NumSpk];
  logic signed [16:0]   step_q [NumSpk];

  // Input register stage
  logic                 s1_valid_q;
  in_item_t             s1_item_q;
  logic signed [GW-1:0] s1_gain_q [NumSpk];

  // Output register
  logic      out_valid_q;
  out_item_t out_q;

  logic in_acc, s1_adv, cfg_wr;

  // Handshake: stage 1 moves on when the output register is free or draining.
  assign s1_adv      = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes and readback.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      six_speakers_q  <= 1'b0;
      source_stereo_q <= 1'b0;
      start_lo_q      <= '0;
      start_hi_q      <= '0;
      end_lo_q        <= '0;
      end_hi_q        <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[5:3]))
        REG_SIX_SPEAKERS:     six_speakers_q  <= pwdata[0];
        REG_SOURCE_STEREO:    source_stereo_q <= pwdata[0];
        REG_START_GAINS_LOW:  start_lo_q      <= pwdata[47:0];
        REG_START_GAINS_HIGH: start_hi_q      <= pwdata[47:0];
        REG_END_GAINS_LOW:    end_lo_q        <= pwdata[47:0];
        REG_END_GAINS_HIGH:   end_hi_q        <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[5:3]))
      REG_SIX_SPEAKERS:     prdata = {63'd0, six_speakers_q};
      REG_SOURCE_STEREO:    prdata = {63'd0, source_stereo_q};
      REG_START_GAINS_LOW:  prdata = {16'd0, start_lo_q};
      REG_START_GAINS_HIGH: prdata = {16'd0, start_hi_q};
      REG_END_GAINS_LOW:    prdata = {16'd0, end_lo_q};
      REG_END_GAINS_HIGH:   prdata = {16'd0, end_hi_q};
      default:              prdata = 64'd0;
    endcase
  end

  // Ramp update: pick the gain for this frame and the gain for the next one.
  logic signed [16:0]   step_new [NumSpk];
  logic signed [16:0]   step_use [NumSpk];
  logic signed [GW-1:0] cur_gain [NumSpk];
  logic signed [GW-1:0] nxt_gain [NumSpk];

  always_comb begin
    logic        [15:0] sg, eg;
    logic signed [GW:0] ld, sum;
    for (int k = 0; k < NumSpk; k++) begin
      sg = (k < 3) ? start_lo_q[16*(k%3) +: 16] : start_hi_q[16*(k%3) +: 16];
      eg = (k < 3) ? end_lo_q[16*(k%3) +: 16]   : end_hi_q[16*(k%3) +: 16];
      step_new[k] = $signed({eg[15], eg}) - $signed({sg[15], sg});
      ld = $signed({sg[15], sg, {L{1'b0}}}) + $signed({{L{step_new[k][16]}}, step_new[k]});
      if (ld > GMax) ld = GMax;
      if (ld < GMin) ld = GMin;
      cur_gain[k] = in_data_i.block_start ? ld[GW-1:0] : run_q[k];
      step_use[k] = in_data_i.block_start ? step_new[k] : step_q[k];
      sum = $signed({cur_gain[k][GW-1], cur_gain[k]})
          + $signed({{L{step_use[k][16]}}, step_use[k]});
      if (sum > GMax) sum = GMax;
      if (sum < GMin) sum = GMin;
      nxt_gain[k] = sum[GW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSpk; k++) begin
        run_q[k]  <= '0;
        step_q[k] <= '0;
      end
    end else if (in_acc) begin
      for (int k = 0; k < NumSpk; k++) begin
        run_q[k]  <= nxt_gain[k];
        step_q[k] <= step_use[k];
      end
    end
  end

  // Input register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_data_i;
      for (int k = 0; k < NumSpk; k++) begin
        s1_gain_q[k] <= cur_gain[k];
      end
    end
  end

  // Multiply, round half up, add to the accumulator and saturate; in two-speaker mode speakers 2-5 pass through.
  logic signed [31:0] mix_in [NumSpk];
  logic signed [31:0] res    [NumSpk];

  assign mix_in[0] = s1_item_q.mix_in_0;
  assign mix_in[1] = s1_item_q.mix_in_1;
  assign mix_in[2] = s1_item_q.mix_in_2;
  assign mix_in[3] = s1_item_q.mix_in_3;
  assign mix_in[4] = s1_item_q.mix_in_4;
  assign mix_in[5] = s1_item_q.mix_in_5;

  always_comb begin
    logic signed [15:0]   smp;
    logic signed [PW-1:0] prod;
    logic signed [PW:0]   rnd;
    logic signed [PW:0]   shf;
    logic signed [16:0]   contrib;
    logic signed [33:0]   acc;
    for (int k = 0; k < NumSpk; k++) begin
      smp = (source_stereo_q && (k == 1 || k == 5)) ?
            s1_item_q.sample_right : s1_item_q.sample_left;
      prod    = smp * s1_gain_q[k];
      rnd     = $signed({prod[PW-1], prod}) + Half;
      shf     = rnd >>> (15 + L);
      contrib = shf[16:0];
      acc     = $signed({{2{mix_in[k][31]}}, mix_in[k]})
              + $signed({{17{contrib[16]}}, contrib});
      if (acc > 34'sh0_7fff_ffff) acc = 34'sh0_7fff_ffff;
      if (acc < -34'sh0_8000_0000) acc = -34'sh0_8000_0000;
      res[k] = (six_speakers_q || k < 2) ? acc[31:0] : mix_in[k];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q.mix_out_0 <= res[0];
      out_q.mix_out_1 <= res[1];
      out_q.mix_out_2 <= res[2];
      out_q.mix_out_3 <= res[3];
      out_q.mix_out_4 <= res[4];
      out_q.mix_out_5 <= res[5];
    end
  end

`ifndef SYNTHESIS
  // An empty input stage never pushes back.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled while the input stage is empty");

  // A frame leaving the input stage shows up as a result.
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> out_valid_o)
    else $error("frame lost between input stage and output register");

  // In two-speaker mode the upper channels pass through unchanged; speaker 2 is checked.
  a_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv && !six_speakers_q) |=>
      out_data_o.mix_out_2 == $past(s1_item_q.mix_in_2))
    else $error("speaker 2 not passed through in two-speaker mode");

  // A block start loads the step from the gain registers; speaker 0 is checked.
  a_step_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.block_start) |=> step_q[0] == $past(step_new[0]))
    else $error("gain step not reloaded at block start");

  // The running gain stays inside the Q1.15 range scaled by the block length.
  for (genvar g = 0; g < NumSpk; g++) begin : g_gain_range
    a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ($signed({run_q[g][GW-1], run_q[g]}) <= GMax)
      && ($signed({run_q[g][GW-1], run_q[g]}) >= GMin))
      else $error("running gain out of range");
  end
`endif

endmodule
